>>> rtl/core/elliptic_ring_sector_inside_test_macros.svh
// assertion macros for the elliptic ring sector test
`ifndef ELLIPTIC_RING_SECTOR_INSIDE_TEST_MACROS_SVH
`define ELLIPTIC_RING_SECTOR_INSIDE_TEST_MACROS_SVH

// same-cycle implication, off while in reset
`define ERS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ERS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// checks what reset leaves behind on the next cycle
`define ERS_ASSERT_AFTER_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ers_pkg.sv
// shared constants, types and arctangent table of the elliptic ring sector test
package ers_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int CORDIC_W          = 64;  // scaled coordinates plus rotation growth
    localparam int SCALE_MSB         = 60;  // coordinates scaled by 2^(SCALE_MSB - coord bits)
    localparam int ZW                = 32;  // internal angle, 2^32 is a full turn
    localparam int ELL_STAGE         = 7;   // pipeline stage where the ellipse flags settle
    localparam int INNER_SEMI_RESET  = 256;
    localparam int OUTER_SEMI_RESET  = 512;
    localparam int CFG_ADDR_W        = 5;
    localparam int CFG_DATA_W        = 32;

    typedef enum logic [2:0] {
        REG_INNER_X    = 3'd0,
        REG_INNER_Y    = 3'd1,
        REG_OUTER_X    = 3'd2,
        REG_OUTER_Y    = 3'd3,
        REG_HALF_ANGLE = 3'd4,
        REG_MEAN_ANGLE = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic inner_ok;  // on or outside the inner ellipse
        logic outer_ok;  // strictly inside the outer ellipse
    } t_ring_flags;

    // atan(2^-idx) in units of a full turn / 2^32
    function automatic logic [ZW-1:0] atan_entry(input int unsigned idx);
        logic [ZW-1:0] v;
        case (idx)
            0:       v = 32'h2000_0000;
            1:       v = 32'h12E4_051E;
            2:       v = 32'h09FB_385B;
            3:       v = 32'h0511_11D4;
            4:       v = 32'h028B_0D43;
            5:       v = 32'h0145_D7E1;
            6:       v = 32'h00A2_F61E;
            7:       v = 32'h0051_7C55;
            8:       v = 32'h0028_BE53;
            9:       v = 32'h0014_5F2F;
            10:      v = 32'h000A_2F98;
            11:      v = 32'h0005_17CC;
            12:      v = 32'h0002_8BE6;
            13:      v = 32'h0001_45F3;
            14:      v = 32'h0000_A2FA;
            15:      v = 32'h0000_517D;
            16:      v = 32'h0000_28BE;
            17:      v = 32'h0000_145F;
            18:      v = 32'h0000_0A30;
            19:      v = 32'h0000_0518;
            20:      v = 32'h0000_028C;
            21:      v = 32'h0000_0146;
            22:      v = 32'h0000_00A3;
            23:      v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/ers_pipe_ctl.sv
// valid bits and per-stage load enables of the point pipeline
module ers_pipe_ctl #(
    parameter int DEPTH = 21
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output logic [DEPTH-1:0] o_stage_en
);

    logic [DEPTH-1:0] r_valid;
    logic [DEPTH-1:0] n_valid;
    logic [DEPTH-1:0] w_prev;

    // a stage may load when it or any stage after it has room, or when the output is not stalled
    for (genvar k = 0; k < DEPTH; k++) begin : g_en
        assign o_stage_en[k] = ~(&r_valid[DEPTH-1:k]) | ~i_out_stall;
    end

    assign w_prev = {r_valid[DEPTH-2:0], i_in_valid};

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            n_valid[k] = o_stage_en[k] ? w_prev[k] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_stall  = ~o_stage_en[0];
    assign o_out_valid = r_valid[DEPTH-1];

endmodule

>>> rtl/core/ers_cordic.sv
// pipelined cordic atan2 and angular sector test
module ers_cordic import ers_pkg::*; #(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                     i_clk,
    input  logic [CORDIC_STAGES+2:0] i_stage_en,
    input  logic [COORD_BITS-1:0]    i_pos_x,
    input  logic [COORD_BITS-1:0]    i_pos_y,
    input  logic [ANGLE_BITS-1:0]    i_half_angle,
    input  logic [ANGLE_BITS-1:0]    i_mean_angle,
    output logic                     o_angle_ok
);

    localparam int SHIFT = SCALE_MSB - COORD_BITS;
    localparam int N     = CORDIC_STAGES;
    localparam logic [ZW-1:0] Z_PI       = {1'b1, {(ZW-1){1'b0}}};
    localparam logic [ZW-1:0] ROUND_HALF = ZW'(1) << (ZW - 1 - ANGLE_BITS);

    logic signed [CORDIC_W-1:0] w_sx;
    logic signed [CORDIC_W-1:0] w_sy;
    logic                       w_org;

    logic signed [CORDIC_W-1:0] r_x   [0:N];
    logic signed [CORDIC_W-1:0] r_y   [0:N];
    logic        [ZW-1:0]       r_z   [0:N];
    logic                       r_org [0:N];

    logic [ZW-1:0]           w_zr;
    logic [ANGLE_BITS-1:0]   r_angle;
    logic [ANGLE_BITS-1:0]   w_off;
    logic signed [ANGLE_BITS:0] w_soff;
    logic signed [ANGLE_BITS:0] w_half;
    logic signed [ANGLE_BITS:0] w_neg_half;

    assign w_sx  = $signed({{(CORDIC_W-COORD_BITS){i_pos_x[COORD_BITS-1]}}, i_pos_x}) <<< SHIFT;
    assign w_sy  = $signed({{(CORDIC_W-COORD_BITS){i_pos_y[COORD_BITS-1]}}, i_pos_y}) <<< SHIFT;
    assign w_org = (i_pos_x == '0) && (i_pos_y == '0);

    always_ff @(posedge i_clk) begin
        // left half plane: rotate by pi first
        if (i_stage_en[0]) begin
            r_org[0] <= w_org;
            if (i_pos_x[COORD_BITS-1]) begin
                r_x[0] <= -w_sx;
                r_y[0] <= -w_sy;
                r_z[0] <= Z_PI;
            end else begin
                r_x[0] <= w_sx;
                r_y[0] <= w_sy;
                r_z[0] <= '0;
            end
        end
        for (int i = 0; i < N; i++) begin
            if (i_stage_en[i+1]) begin
                r_org[i+1] <= r_org[i];
                if (!r_y[i][CORDIC_W-1]) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_entry(i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_entry(i);
                end
            end
        end
    end

    // round to the output angle width, origin reads as angle zero
    assign w_zr = r_z[N] + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_stage_en[N+1]) begin
            r_angle <= r_org[N] ? '0 : w_zr[ZW-1 -: ANGLE_BITS];
        end
    end

    assign w_off      = r_angle - i_mean_angle;
    assign w_soff     = $signed({w_off[ANGLE_BITS-1], w_off});
    assign w_half     = $signed({1'b0, i_half_angle});
    assign w_neg_half = -w_half;

    always_ff @(posedge i_clk) begin
        if (i_stage_en[N+2]) begin
            o_angle_ok <= (w_soff >= w_neg_half) && (w_soff < w_half);
        end
    end

endmodule

>>> rtl/core/ers_ellipse.sv
// pipelined inner and outer ellipse tests by cross multiplication
module ers_ellipse import ers_pkg::*; #(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                     i_clk,
    input  logic [CORDIC_STAGES+2:0] i_stage_en,
    input  logic [COORD_BITS-1:0]    i_pos_x,
    input  logic [COORD_BITS-1:0]    i_pos_y,
    input  logic [COORD_BITS-2:0]    i_inner_x,
    input  logic [COORD_BITS-2:0]    i_inner_y,
    input  logic [COORD_BITS-2:0]    i_outer_x,
    input  logic [COORD_BITS-2:0]    i_outer_y,
    output t_ring_flags              o_flags
);

    localparam int MW    = COORD_BITS;          // magnitude width
    localparam int SW    = COORD_BITS - 1;      // semi-axis width
    localparam int PPW   = MW + SW;             // partial product
    localparam int S0W   = MW + 2 * SW;         // half-operand by full operand
    localparam int PW    = 2 * MW + 2 * SW;     // full product
    localparam int NPROD = 6;
    localparam int FIRST = ELL_STAGE - 1;       // local index of the compare stage
    localparam int LAST  = CORDIC_STAGES + 2;

    logic [MW-1:0]   r_ax;
    logic [MW-1:0]   r_ay;
    logic [2*MW-1:0] r_x2;
    logic [2*MW-1:0] r_y2;
    logic [2*SW-1:0] r_ai2;
    logic [2*SW-1:0] r_bi2;
    logic [2*SW-1:0] r_ao2;
    logic [2*SW-1:0] r_bo2;

    logic [2*MW-1:0] w_opa [0:NPROD-1];
    logic [2*SW-1:0] w_opb [0:NPROD-1];
    logic [PPW-1:0]  r_pp_ll [0:NPROD-1];
    logic [PPW-1:0]  r_pp_lh [0:NPROD-1];
    logic [PPW-1:0]  r_pp_hl [0:NPROD-1];
    logic [PPW-1:0]  r_pp_hh [0:NPROD-1];
    logic [S0W-1:0]  r_s0    [0:NPROD-1];
    logic [S0W-1:0]  r_s1    [0:NPROD-1];
    logic [PW-1:0]   r_prod  [0:NPROD-1];

    logic [PW:0]     r_lhs_in;
    logic [PW:0]     r_lhs_out;
    logic [PW-1:0]   r_c_in;
    logic [PW-1:0]   r_c_out;
    t_ring_flags     r_flags [FIRST:LAST];

    // operand pairs: x2*bi2, y2*ai2, x2*bo2, y2*ao2, ai2*bi2, ao2*bo2
    always_comb begin
        w_opa[0] = r_x2;
        w_opb[0] = r_bi2;
        w_opa[1] = r_y2;
        w_opb[1] = r_ai2;
        w_opa[2] = r_x2;
        w_opb[2] = r_bo2;
        w_opa[3] = r_y2;
        w_opb[3] = r_ao2;
        w_opa[4] = (2*MW)'(r_ai2);
        w_opb[4] = r_bi2;
        w_opa[5] = (2*MW)'(r_ao2);
        w_opb[5] = r_bo2;
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[0]) begin
            r_ax <= i_pos_x[MW-1] ? (~i_pos_x + 1'b1) : i_pos_x;
            r_ay <= i_pos_y[MW-1] ? (~i_pos_y + 1'b1) : i_pos_y;
        end
        if (i_stage_en[1]) begin
            r_x2  <= r_ax * r_ax;
            r_y2  <= r_ay * r_ay;
            r_ai2 <= i_inner_x * i_inner_x;
            r_bi2 <= i_inner_y * i_inner_y;
            r_ao2 <= i_outer_x * i_outer_x;
            r_bo2 <= i_outer_y * i_outer_y;
        end
        for (int k = 0; k < NPROD; k++) begin
            if (i_stage_en[2]) begin
                r_pp_ll[k] <= w_opa[k][MW-1:0]    * w_opb[k][SW-1:0];
                r_pp_lh[k] <= w_opa[k][MW-1:0]    * w_opb[k][2*SW-1:SW];
                r_pp_hl[k] <= w_opa[k][2*MW-1:MW] * w_opb[k][SW-1:0];
                r_pp_hh[k] <= w_opa[k][2*MW-1:MW] * w_opb[k][2*SW-1:SW];
            end
            if (i_stage_en[3]) begin
                r_s0[k] <= S0W'(r_pp_ll[k]) + (S0W'(r_pp_lh[k]) << SW);
                r_s1[k] <= S0W'(r_pp_hl[k]) + (S0W'(r_pp_hh[k]) << SW);
            end
            if (i_stage_en[4]) begin
                r_prod[k] <= PW'(r_s0[k]) + (PW'(r_s1[k]) << MW);
            end
        end
        if (i_stage_en[5]) begin
            r_lhs_in  <= (PW+1)'(r_prod[0]) + (PW+1)'(r_prod[1]);
            r_lhs_out <= (PW+1)'(r_prod[2]) + (PW+1)'(r_prod[3]);
            r_c_in    <= r_prod[4];
            r_c_out   <= r_prod[5];
        end
        if (i_stage_en[FIRST]) begin
            r_flags[FIRST].inner_ok <= r_lhs_in >= (PW+1)'(r_c_in);
            r_flags[FIRST].outer_ok <= r_lhs_out < (PW+1)'(r_c_out);
        end
        // carry the flags alongside the cordic stages
        for (int j = FIRST + 1; j <= LAST; j++) begin
            if (i_stage_en[j]) begin
                r_flags[j] <= r_flags[j-1];
            end
        end
    end

    assign o_flags = r_flags[LAST];

endmodule

>>> rtl/core/elliptic_ring_sector_inside_test.sv
// elliptic ring sector test: one point in, one inside flag out per transfer
// throughput: one point per cycle while o_in_stall is low,
// and one register stage per cordic iteration
// a stalled output holds its stage; earlier empty stages keep taking points
// reset: synchronous, active low; clears valid bits and loads register defaults
module elliptic_ring_sector_inside_test import ers_pkg::*; #(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_is_inside,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int DEPTH = CORDIC_STAGES + 5;
    localparam int SW    = COORD_BITS - 1;
    localparam logic [ANGLE_BITS-1:0] HALF_RESET = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    logic [SW-1:0]         r_inner_x;
    logic [SW-1:0]         r_inner_y;
    logic [SW-1:0]         r_outer_x;
    logic [SW-1:0]         r_outer_y;
    logic [ANGLE_BITS-1:0] r_half_angle;
    logic [ANGLE_BITS-1:0] r_mean_angle;

    logic                  w_cfg_wr;
    t_reg_idx              w_reg_idx;

    logic [DEPTH-1:0]      w_en;
    logic [COORD_BITS-1:0] r_pos_x;
    logic [COORD_BITS-1:0] r_pos_y;
    logic                  w_angle_ok;
    t_ring_flags           w_flags;
    logic                  r_inside;

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_x    <= SW'(INNER_SEMI_RESET);
            r_inner_y    <= SW'(INNER_SEMI_RESET);
            r_outer_x    <= SW'(OUTER_SEMI_RESET);
            r_outer_y    <= SW'(OUTER_SEMI_RESET);
            r_half_angle <= HALF_RESET;
            r_mean_angle <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_INNER_X:    r_inner_x    <= pwdata[SW-1:0];
                REG_INNER_Y:    r_inner_y    <= pwdata[SW-1:0];
                REG_OUTER_X:    r_outer_x    <= pwdata[SW-1:0];
                REG_OUTER_Y:    r_outer_y    <= pwdata[SW-1:0];
                REG_HALF_ANGLE: r_half_angle <= pwdata[ANGLE_BITS-1:0];
                REG_MEAN_ANGLE: r_mean_angle <= pwdata[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_INNER_X:    prdata = CFG_DATA_W'(r_inner_x);
            REG_INNER_Y:    prdata = CFG_DATA_W'(r_inner_y);
            REG_OUTER_X:    prdata = CFG_DATA_W'(r_outer_x);
            REG_OUTER_Y:    prdata = CFG_DATA_W'(r_outer_y);
            REG_HALF_ANGLE: prdata = CFG_DATA_W'(r_half_angle);
            REG_MEAN_ANGLE: prdata = CFG_DATA_W'(r_mean_angle);
            default:        prdata = '0;
        endcase
    end

    ers_pipe_ctl #(
        .DEPTH (DEPTH)
    ) u_pipe_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_stage_en  (w_en)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pos_x <= i_pos_x;
            r_pos_y <= i_pos_y;
        end
    end

    ers_cordic #(
        .COORD_BITS    (COORD_BITS),
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk        (i_clk),
        .i_stage_en   (w_en[CORDIC_STAGES+3:1]),
        .i_pos_x      (r_pos_x),
        .i_pos_y      (r_pos_y),
        .i_half_angle (r_half_angle),
        .i_mean_angle (r_mean_angle),
        .o_angle_ok   (w_angle_ok)
    );

    ers_ellipse #(
        .COORD_BITS    (COORD_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_ellipse (
        .i_clk      (i_clk),
        .i_stage_en (w_en[CORDIC_STAGES+3:1]),
        .i_pos_x    (r_pos_x),
        .i_pos_y    (r_pos_y),
        .i_inner_x  (r_inner_x),
        .i_inner_y  (r_inner_y),
        .i_outer_x  (r_outer_x),
        .i_outer_y  (r_outer_y),
        .o_flags    (w_flags)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (w_en[DEPTH-1]) begin
            r_inside <= w_angle_ok & w_flags.inner_ok & w_flags.outer_ok;
        end
    end

    assign o_is_inside = r_inside;

endmodule

>>> rtl/core/ers_checker.sv
// port-level checks of the elliptic ring sector test, bound to the top level
`include "elliptic_ring_sector_inside_test_macros.svh"

module ers_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_is_inside
);

    // a held result keeps its value until transferred
    `ERS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_is_inside), "stalled result changed or vanished")

    // input backs up only while a valid result is stalled at the output
    `ERS_ASSERT_NOW(a_in_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled with room in the pipeline")

    // reset leaves no result behind
    `ERS_ASSERT_AFTER_RESET(a_reset_empty, i_clk, i_rst_n, !o_out_valid, "result valid right after reset")

endmodule

bind elliptic_ring_sector_inside_test ers_checker u_ers_checker (.*);
